[hw/rtl/mrlp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the meter reply line parser.
// No dependencies; imported by meter_reply_line_parser.
package mrlp_pkg;

  localparam int CHUNK_MAX_DEF   = 256;
  localparam int DATA_FIELDS_DEF = 18;

  localparam int          TOK_W   = 12;
  localparam logic [11:0] LEN_CAP = 12'd4095;
  localparam logic [15:0] SAT16   = 16'hFFFF;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SHORT    = 4'd1;
  localparam logic [3:0] ST_NO_START = 4'd2;
  localparam logic [3:0] ST_FEW      = 4'd3;
  localparam logic [3:0] ST_BAD_CMD  = 4'd4;
  localparam logic [3:0] ST_BAD_SUB  = 4'd5;
  localparam logic [3:0] ST_NO_COUNT = 4'd6;
  localparam logic [3:0] ST_MISMATCH = 4'd7;
  localparam logic [3:0] ST_IGNORED  = 4'd8;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } mrlp_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  command_char;
    logic [15:0] watts_tenths;
    logic [15:0] volts_tenths;
  } mrlp_out_t;

endpackage

[hw/rtl/meter_reply_line_parser.sv]
`timescale 1ns / 1ps
// Top level of the meter reply line parser: input register, packet tracker, result register.
// Depends on mrlp_pkg for payload types, character and status codes.
//
// Takes one byte of a meter reply chunk per cycle and, on the byte flagged as
// the chunk's last, delivers one result: a status code, the command letter and,
// for a 'd','-' reply with DATA_FIELDS data fields, power and voltage in tenths.
// Each byte passes an input register and then updates the packet tracker, so a
// byte can be taken on every clock unless in_stall holds it back; the result
// for a chunk is written to the result register when its last byte leaves
// the input register, and is held under out_stall while further bytes flow
// until the next chunk end reaches the tracker. CHUNK_MAX bounds the content
// length of a chunk; later bytes up to the chunk end are dropped. No reset sweep is needed.
module meter_reply_line_parser
  import mrlp_pkg::*;
#(
  parameter int CHUNK_MAX   = CHUNK_MAX_DEF,
  parameter int DATA_FIELDS = DATA_FIELDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mrlp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mrlp_out_t out_data
);

  localparam int CW = $clog2(CHUNK_MAX + 1);

  localparam logic [2:0] FLD_CMD   = 3'd0;
  localparam logic [2:0] FLD_SUB   = 3'd1;
  localparam logic [2:0] FLD_COUNT = 3'd2;
  localparam logic [2:0] FLD_WATTS = 3'd3;
  localparam logic [2:0] FLD_VOLTS = 3'd4;
  localparam logic [2:0] FLD_SAT   = 3'd7;

  localparam logic [1:0] NUM_IDLE   = 2'd0;
  localparam logic [1:0] NUM_DIGITS = 2'd1;
  localparam logic [1:0] NUM_DONE   = 2'd2;

  localparam logic [1:0] LEN_ZERO = 2'd0;
  localparam logic [1:0] LEN_ONE  = 2'd1;
  localparam logic [1:0] LEN_TWO  = 2'd2;
  localparam logic [1:0] LEN_MORE = 2'd3;

  typedef struct packed {
    logic             closed;
    logic [2:0]       fidx;
    logic [TOK_W-1:0] tokens;
    logic [1:0]       tlen;
    logic             spaces;
    logic [7:0]       first;
    logic [7:0]       second;
    logic [1:0]       phase;
    logic             neg;
    logic [15:0]      mag;
    logic [8:0]       cmd;
    logic [8:0]       sub;
    logic [15:0]      cnt_val;
    logic             cnt_pres;
    logic             cnt_neg;
    logic [15:0]      watts;
    logic [15:0]      volts;
  } pkt_t;

  function automatic logic f_blank(input logic [7:0] b);
    f_blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic f_digit(input logic [7:0] b);
    f_digit = (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic pkt_t f_clear_field(input pkt_t p);
    pkt_t q;
    q        = p;
    q.tlen   = LEN_ZERO;
    q.spaces = 1'b0;
    q.first  = '0;
    q.second = '0;
    q.phase  = NUM_IDLE;
    q.neg    = 1'b0;
    q.mag    = '0;
    return q;
  endfunction

  function automatic pkt_t f_track(input pkt_t p, input logic [7:0] b);
    pkt_t        q;
    logic [19:0] m;
    q = p;
    m = ({4'b0, p.mag} << 3) + ({4'b0, p.mag} << 1) + {16'b0, b[3:0] - CH_0[3:0]};
    if (f_blank(b)) begin
      if (p.tlen != LEN_ZERO) begin
        q.spaces = 1'b1;
        if (p.phase == NUM_DIGITS) q.phase = NUM_DONE;
      end
    end else if (p.tlen == LEN_ZERO) begin
      q.tlen  = LEN_ONE;
      q.first = b;
      if (b == CH_PLUS) begin
        q.phase = NUM_DIGITS;
      end else if (b == CH_DASH) begin
        q.neg   = 1'b1;
        q.phase = NUM_DIGITS;
      end else if (f_digit(b)) begin
        q.mag   = {12'b0, b[3:0] - CH_0[3:0]};
        q.phase = NUM_DIGITS;
      end else begin
        q.phase = NUM_DONE;
      end
    end else begin
      if (p.tlen == LEN_ONE && !p.spaces) begin
        q.second = b;
        q.tlen   = LEN_TWO;
      end else begin
        q.tlen = LEN_MORE;
      end
      q.spaces = 1'b0;
      if (p.phase == NUM_DIGITS) begin
        if (f_digit(b)) begin
          q.mag = (m > {4'b0, SAT16}) ? SAT16 : m[15:0];
        end else begin
          q.phase = NUM_DONE;
        end
      end
    end
    return q;
  endfunction

  function automatic pkt_t f_finish(input pkt_t p);
    pkt_t        q;
    logic        nz_neg;
    logic [15:0] pos;
    q      = p;
    nz_neg = p.neg && (p.mag != 16'd0);
    pos    = nz_neg ? 16'd0 : p.mag;
    unique case (p.fidx)
      FLD_CMD: begin
        if (p.tlen == LEN_TWO && p.first == CH_HASH) q.cmd = {1'b1, p.second};
      end
      FLD_SUB: begin
        if (p.tlen == LEN_ONE) q.sub = {1'b1, p.first};
      end
      FLD_COUNT: begin
        q.cnt_pres = (p.tlen != LEN_ZERO);
        q.cnt_val  = p.mag;
        q.cnt_neg  = nz_neg;
      end
      FLD_WATTS: q.watts = pos;
      FLD_VOLTS: q.volts = pos;
      default: q = p;
    endcase
    return q;
  endfunction

  function automatic pkt_t f_feed(input pkt_t p, input logic [7:0] b, input logic seen);
    pkt_t q;
    q = p;
    if (seen && !p.closed) begin
      if (b == CH_SEMI) begin
        q.closed = 1'b1;
      end else if (b == CH_COMMA) begin
        q = f_finish(p);
        if (p.fidx != FLD_SAT) q.fidx = p.fidx + 3'd1;
        if (p.tokens != LEN_CAP) q.tokens = p.tokens + {{(TOK_W-1){1'b0}}, 1'b1};
        q = f_clear_field(q);
      end else begin
        q = f_track(p, b);
      end
    end
    return q;
  endfunction

  mrlp_in_t  in_r;
  logic      in_valid_r;
  mrlp_out_t out_r;
  logic      out_valid_r;

  pkt_t          pkt_r, pkt_nxt, pkt_sel, pkt_restart, pkt_zero, fin;
  logic [CW-1:0] cc_r, cc_nxt, cc_inc;
  logic          te_r, te_nxt;
  logic          ss_r, ss_nxt;
  logic          hh_r, hh_nxt;
  logic          last;
  logic          adv;
  logic          done;
  logic [TOK_W-1:0] tok_m3;
  mrlp_out_t     res;

  assign adv       = in_valid_r && (!in_r.chunk_end || !out_valid_r || !out_stall);
  assign done      = adv && in_r.chunk_end;
  assign in_stall  = in_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    pkt_zero        = '0;
    pkt_restart     = '0;
    pkt_restart.tokens = {{(TOK_W-1){1'b0}}, 1'b1};
    pkt_restart.tlen   = LEN_ONE;
    pkt_restart.first  = CH_HASH;
    pkt_restart.phase  = NUM_DONE;

    pkt_nxt = pkt_r;
    cc_nxt  = cc_r;
    te_nxt  = te_r;
    ss_nxt  = ss_r;
    hh_nxt  = hh_r;
    cc_inc  = cc_r + {{(CW-1){1'b0}}, 1'b1};
    last    = in_r.chunk_end || (cc_inc >= CW'(CHUNK_MAX));
    pkt_sel = hh_r ? pkt_restart : pkt_r;
    if (!te_r) begin
      if (in_r.rx_byte == CH_NUL) begin
        te_nxt = 1'b1;
        hh_nxt = 1'b0;
        if (hh_r) pkt_nxt = f_feed(pkt_r, CH_HASH, ss_r);
      end else begin
        cc_nxt = cc_inc;
        hh_nxt = 1'b0;
        if (hh_r) ss_nxt = 1'b1;
        if (in_r.rx_byte == CH_HASH && !last) begin
          hh_nxt  = 1'b1;
          pkt_nxt = pkt_sel;
        end else begin
          pkt_nxt = f_feed(pkt_sel, in_r.rx_byte, ss_nxt);
        end
        if (last) te_nxt = 1'b1;
      end
    end

    fin    = f_finish(pkt_nxt);
    tok_m3 = fin.tokens - TOK_W'(3);
    res    = '0;
    priority if (cc_nxt < CW'(3)) begin
      res.status = ST_SHORT;
    end else if (!ss_nxt) begin
      res.status = ST_NO_START;
    end else if (fin.tokens < TOK_W'(3)) begin
      res.status = ST_FEW;
    end else if (!fin.cmd[8]) begin
      res.status = ST_BAD_CMD;
    end else begin
      res.command_char = fin.cmd[7:0];
      priority if (!fin.sub[8]) begin
        res.status = ST_BAD_SUB;
      end else if (!fin.cnt_pres) begin
        res.status = ST_NO_COUNT;
      end else if (fin.cnt_neg || fin.cnt_val != {{(16-TOK_W){1'b0}}, tok_m3}) begin
        res.status = ST_MISMATCH;
      end else if (fin.cmd[7:0] == CH_D && fin.sub[7:0] == CH_DASH &&
                   tok_m3 == TOK_W'(DATA_FIELDS)) begin
        res.status       = ST_OK;
        res.watts_tenths = fin.watts;
        res.volts_tenths = fin.volts;
      end else begin
        res.status = ST_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pkt_r       <= '0;
      cc_r        <= '0;
      te_r        <= 1'b0;
      ss_r        <= 1'b0;
      hh_r        <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (done) begin
        pkt_r <= pkt_zero;
        cc_r  <= '0;
        te_r  <= 1'b0;
        ss_r  <= 1'b0;
        hh_r  <= 1'b0;
      end else if (adv) begin
        pkt_r <= pkt_nxt;
        cc_r  <= cc_nxt;
        te_r  <= te_nxt;
        ss_r  <= ss_nxt;
        hh_r  <= hh_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_data;
    if (done) out_r <= res;
  end

  a_rise_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done))
    else $error("result appeared without a chunk end");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (cc_r == '0) && !ss_r && !hh_r && !te_r)
    else $error("chunk state not cleared after chunk end");

  a_ok_is_d: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == ST_OK) |-> out_r.command_char == CH_D)
    else $error("ok status with wrong command");

  a_values_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status != ST_OK) |->
      (out_r.watts_tenths == 16'd0) && (out_r.volts_tenths == 16'd0))
    else $error("readings on a non-ok result");

endmodule
